@@ rtl/pairwise_order_concordance_macros.svh @@
// ----------------------------------------------------------------------------
// pairwise order concordance assertion macros
// shared property wrappers, clocked on aclk and held off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_ORDER_CONCORDANCE_MACROS_SVH
`define PAIRWISE_ORDER_CONCORDANCE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define POC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pairwise order concordance check failed");

// consequent must hold in the cycle after the antecedent
`define POC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pairwise order concordance check failed");

`endif

@@ rtl/poc_pkg.sv @@
// ----------------------------------------------------------------------------
// poc_pkg
// shared field widths, stream widths and result status codes
// ----------------------------------------------------------------------------
package poc_pkg;

    // input field widths
    localparam int IN_VALUE_W = 32;
    localparam int S_DATA_W   = 2 * IN_VALUE_W;

    // result field widths
    localparam int Q_W       = 17;
    localparam int Q_FRAC_W  = 16;
    localparam int SCORE_W   = 12;
    localparam int PAIRS_W   = 11;
    localparam int STATUS_W  = 2;
    localparam int M_FIELD_W = Q_W + SCORE_W + PAIRS_W + STATUS_W;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    // accuracy reported when no pair counts
    localparam logic [Q_W-1:0] Q16_ONE = Q_W'(1) << Q_FRAC_W;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_MASS  = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

endpackage

@@ rtl/poc_store.sv @@
// ----------------------------------------------------------------------------
// poc_store
// entry memory, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module poc_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WORD_W = 64
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/poc_walker.sv @@
// ----------------------------------------------------------------------------
// poc_walker
// walks all index pairs through the entry memory, reading each row's anchor first,
// holding the lower entry of each row as the anchor and scoring against it
// ----------------------------------------------------------------------------
module poc_walker #(
    parameter int ADDR_W  = 6,
    parameter int COUNT_W = 7,
    parameter int VALUE_W = 32,
    parameter int PAIR_W  = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [COUNT_W-1:0]   n,
    output logic                 rd_en,
    output logic [ADDR_W-1:0]    rd_addr,
    input  logic [2*VALUE_W-1:0] rd_data,
    output logic                 done,
    output logic [PAIR_W:0]      score,
    output logic [PAIR_W-1:0]    pairs
);

    logic                 issue_reg;
    logic                 anchor_ph_reg;
    logic [ADDR_W-1:0]    a_reg;
    logic [ADDR_W-1:0]    b_reg;
    logic [COUNT_W-1:0]   nm1_reg;
    logic                 rvalid_reg;
    logic                 ranchor_reg;
    logic                 done_reg;
    logic [VALUE_W-1:0]   anc_p_reg;
    logic [VALUE_W-1:0]   anc_t_reg;
    logic [PAIR_W:0]      score_reg;
    logic [PAIR_W-1:0]    pairs_reg;

    logic                 last_b;
    logic                 last_a;
    logic [VALUE_W-1:0]   cur_p;
    logic [VALUE_W-1:0]   cur_t;
    logic [1:0]           pair_pts;

    // end of row and end of walk
    assign last_b = (COUNT_W'(b_reg) == nm1_reg);
    assign last_a = ((COUNT_W'(a_reg) + COUNT_W'(1)) == nm1_reg);

    // read request, anchor first then the rest of the row
    assign rd_en   = issue_reg;
    assign rd_addr = anchor_ph_reg ? a_reg : b_reg;

    // read data fields
    assign cur_p = rd_data[VALUE_W-1:0];
    assign cur_t = rd_data[2*VALUE_W-1:VALUE_W];

    // points for one pair in halves
    always_comb begin
        pair_pts = 2'd0;
        if (anc_p_reg == cur_p) begin
            pair_pts = 2'd1;
        end else if ((anc_p_reg > cur_p) == (anc_t_reg > cur_t)) begin
            pair_pts = 2'd2;
        end
    end

    // address sequencer and read pipeline tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg     <= 1'b0;
            anchor_ph_reg <= 1'b0;
            rvalid_reg    <= 1'b0;
            ranchor_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            rvalid_reg  <= issue_reg;
            ranchor_reg <= anchor_ph_reg;
            done_reg    <= 1'b0;
            if (start) begin
                a_reg         <= '0;
                nm1_reg       <= n - COUNT_W'(1);
                anchor_ph_reg <= 1'b1;
                if (n < COUNT_W'(2)) begin
                    done_reg <= 1'b1;
                end else begin
                    issue_reg <= 1'b1;
                end
            end else if (issue_reg) begin
                if (anchor_ph_reg) begin
                    anchor_ph_reg <= 1'b0;
                    b_reg         <= a_reg + 1'b1;
                end else if (last_b) begin
                    if (last_a) begin
                        issue_reg <= 1'b0;
                    end else begin
                        a_reg         <= a_reg + 1'b1;
                        anchor_ph_reg <= 1'b1;
                    end
                end else begin
                    b_reg <= b_reg + 1'b1;
                end
            end else if (rvalid_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    // anchor capture and score accumulation
    always_ff @(posedge aclk) begin
        if (start) begin
            score_reg <= '0;
            pairs_reg <= '0;
        end else if (rvalid_reg) begin
            if (ranchor_reg) begin
                anc_p_reg <= cur_p;
                anc_t_reg <= cur_t;
            end else if (anc_t_reg != cur_t) begin
                pairs_reg <= pairs_reg + 1'b1;
                score_reg <= score_reg + (PAIR_W + 1)'(pair_pts);
            end
        end
    end

    assign done  = done_reg;
    assign score = score_reg;
    assign pairs = pairs_reg;

endmodule

@@ rtl/poc_divider.sv @@
// ----------------------------------------------------------------------------
// poc_divider
// restoring divider, one quotient bit per cycle while busy, for the q16 accuracy
// ----------------------------------------------------------------------------
module poc_divider #(
    parameter int PAIR_W = 11
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [PAIR_W:0]        score,
    input  logic [PAIR_W-1:0]      pairs,
    output logic                   done,
    output logic [poc_pkg::Q_W-1:0] quot
);

    import poc_pkg::*;

    localparam int DW    = PAIR_W + Q_FRAC_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    dsh_reg;
    logic [Q_W-1:0]   q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ge;

    assign ge = (rem_reg >= dsh_reg);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath: dividend is score in halves scaled to q16 plus half the divisor
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {score, {(Q_FRAC_W - 1){1'b0}}} + DW'(pairs >> 1);
            dsh_reg <= {pairs, {Q_FRAC_W{1'b0}}};
            q_reg   <= '0;
            cnt_reg <= CNT_W'(Q_W);
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[Q_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

@@ rtl/pairwise_order_concordance.sv @@
// a run that overflows the store or has no weight mass on one side reports its status without a walk;
// otherwise the walker reads each row's anchor, then the rest of the row, through the single
// read port of the entry memory, and the divider forms the accuracy unless no pair counted.
// No new entry is taken until the result of a run has been loaded into the output register.
// reset: synchronous, active low; clears the run counters and the handshake state
// ----------------------------------------------------------------------------
// pairwise_order_concordance
// loads predicted/target weight entries and, on the last entry, scores how
// often the predicted order agrees with the target order over untied-target index pairs
// ----------------------------------------------------------------------------
`include "pairwise_order_concordance_macros.svh"

module pairwise_order_concordance #(
    parameter int MAX_ENTRIES = 64,
    parameter int VALUE_BITS  = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // predicted_value [31:0], target_value [63:32]
    input  logic [poc_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // accuracy_q16 [16:0], score_halves [28:17], pairs_counted [39:29], status [41:40]
    output logic [poc_pkg::M_DATA_W-1:0] m_tdata
);

    import poc_pkg::*;

    localparam int VW = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = $clog2(MAX_ENTRIES * (MAX_ENTRIES - 1) / 2 + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_WALK,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 pmass_reg, pmass_next;
    logic                 tmass_reg, tmass_next;
    logic                 ovf_reg, ovf_next;
    status_t              status_reg, status_next;
    logic [Q_W-1:0]       acc_reg, acc_next;
    logic [PW:0]          score_reg, score_next;
    logic [PW-1:0]        pairs_reg, pairs_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic                 s_accept;
    logic                 full;
    logic [VW-1:0]        in_p;
    logic [VW-1:0]        in_t;
    logic                 ovf_now, pmass_now, tmass_now;

    logic                 wr_en;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [2*VW-1:0]      rd_data;

    logic                 walk_start;
    logic                 walk_done;
    logic [PW:0]          walk_score;
    logic [PW-1:0]        walk_pairs;
    logic                 div_start;
    logic                 div_done;
    logic [Q_W-1:0]       div_quot;

    // input transfer and weight masking
    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(MAX_ENTRIES));
    assign in_p     = s_tdata[VW-1:0];
    assign in_t     = s_tdata[IN_VALUE_W+VW-1:IN_VALUE_W];
    assign wr_en    = s_accept && !full;

    assign ovf_now   = ovf_reg || full;
    assign pmass_now = pmass_reg || (in_p != '0);
    assign tmass_now = tmass_reg || (in_t != '0);

    poc_store #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (AW),
        .WORD_W (2 * VW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({in_t, in_p}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    poc_walker #(
        .ADDR_W  (AW),
        .COUNT_W (CW),
        .VALUE_W (VW),
        .PAIR_W  (PW)
    ) u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (walk_start),
        .n       (count_next),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .done    (walk_done),
        .score   (walk_score),
        .pairs   (walk_pairs)
    );

    poc_divider #(
        .PAIR_W (PW)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .score   (walk_score),
        .pairs   (walk_pairs),
        .done    (div_done),
        .quot    (div_quot)
    );

    // sequencing of load, walk, divide and result
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        pmass_next    = pmass_reg;
        tmass_next    = tmass_reg;
        ovf_next      = ovf_reg;
        status_next   = status_reg;
        acc_next      = acc_reg;
        score_next    = score_reg;
        pairs_next    = pairs_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        walk_start    = 1'b0;
        div_start     = 1'b0;

        // result transfer
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (!full) begin
                        count_next = count_reg + 1'b1;
                    end
                    ovf_next   = ovf_now;
                    pmass_next = pmass_now;
                    tmass_next = tmass_now;
                    if (s_tlast) begin
                        acc_next   = '0;
                        score_next = '0;
                        pairs_next = '0;
                        if (ovf_now) begin
                            status_next = STATUS_OVERFLOW;
                            state_next  = ST_EMIT;
                        end else if (!pmass_now || !tmass_now) begin
                            status_next = STATUS_NO_MASS;
                            state_next  = ST_EMIT;
                        end else begin
                            status_next = STATUS_OK;
                            walk_start  = 1'b1;
                            state_next  = ST_WALK;
                        end
                    end
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    score_next = walk_score;
                    pairs_next = walk_pairs;
                    if (walk_pairs == '0) begin
                        acc_next   = Q16_ONE;
                        state_next = ST_EMIT;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    acc_next   = div_quot;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // wait for the output register, then start a new run
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({status_reg,
                                               PAIRS_W'(pairs_reg),
                                               SCORE_W'(score_reg),
                                               acc_reg});
                    count_next    = '0;
                    pmass_next    = 1'b0;
                    tmass_next    = 1'b0;
                    ovf_next      = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            pmass_reg    <= 1'b0;
            tmass_reg    <= 1'b0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pmass_reg    <= pmass_next;
            tmass_reg    <= tmass_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        status_reg  <= status_next;
        acc_reg     <= acc_next;
        score_reg   <= score_next;
        pairs_reg   <= pairs_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `POC_ASSERT_NOW(a_walk_done_in_walk, walk_done, state_reg == ST_WALK)
    `POC_ASSERT_NOW(a_div_done_in_div, div_done, state_reg == ST_DIV)
    `POC_ASSERT_NOW(a_error_fields_zero, state_reg == ST_EMIT && status_reg != STATUS_OK, acc_reg == '0 && score_reg == '0 && pairs_reg == '0)
    `POC_ASSERT_NEXT(a_full_sets_overflow, s_accept && full && !s_tlast, ovf_reg)

endmodule

@@ test/tb_pairwise_order_concordance.sv @@
// ----------------------------------------------------------------------------
// tb_pairwise_order_concordance
// drives runs of predicted/target weight entries into the block and checks
// every result transfer against an in-bench concordance predictor; covers
// ties, zero mass, full and overflowing stores under random stalls
// ----------------------------------------------------------------------------
import poc_pkg::*;

// result transfer layout, highest field first
typedef struct packed {
    logic [M_DATA_W-M_FIELD_W-1:0] pad;
    status_t                       status;
    logic [PAIRS_W-1:0]            pairs;
    logic [SCORE_W-1:0]            score;
    logic [Q_W-1:0]                acc;
} concordance_result_t;

// concordance predictor and result scoreboard
class concordance_scoreboard;
    localparam int STORE_DEPTH = 64;

    bit [IN_VALUE_W-1:0]   pred_mem [STORE_DEPTH];
    bit [IN_VALUE_W-1:0]   targ_mem [STORE_DEPTH];
    int unsigned           fill;
    bit                    pred_mass;
    bit                    targ_mass;
    bit                    spilled;
    concordance_result_t   expected_q [$];
    int unsigned           mismatches;
    int unsigned           n_entries;
    int unsigned           n_checked;
    int unsigned           n_scored;
    int unsigned           n_no_mass;
    int unsigned           n_overflow;
    int unsigned           max_pairs;

    // accepted entry: store it, and on the last one predict the result
    function void note_entry(bit [IN_VALUE_W-1:0] pv, bit [IN_VALUE_W-1:0] tv, bit lst);
        concordance_result_t r;
        int unsigned score;
        int unsigned pairs;
        n_entries++;
        if (fill < STORE_DEPTH) begin
            pred_mem[fill] = pv;
            targ_mem[fill] = tv;
            fill++;
        end else begin
            spilled = 1'b1;
        end
        if (pv != 0) pred_mass = 1'b1;
        if (tv != 0) targ_mass = 1'b1;
        if (!lst) return;

        r = '0;
        score = 0;
        pairs = 0;
        if (spilled) begin
            r.status = STATUS_OVERFLOW;
            n_overflow++;
        end else if (!pred_mass || !targ_mass) begin
            r.status = STATUS_NO_MASS;
            n_no_mass++;
        end else begin
            // walk all index pairs, skipping tied targets
            for (int a = 0; a < fill; a++) begin
                for (int b = a + 1; b < fill; b++) begin
                    if (targ_mem[a] == targ_mem[b]) continue;
                    pairs++;
                    if (pred_mem[a] == pred_mem[b])
                        score += 1;
                    else if ((pred_mem[a] > pred_mem[b]) == (targ_mem[a] > targ_mem[b]))
                        score += 2;
                end
            end
            r.status = STATUS_OK;
            r.score  = score[SCORE_W-1:0];
            r.pairs  = pairs[PAIRS_W-1:0];
            if (pairs == 0)
                r.acc = Q16_ONE;
            else
                r.acc = Q_W'((score * 32768 + pairs / 2) / pairs);
            if (pairs > max_pairs) max_pairs = pairs;
            n_scored++;
        end
        expected_q.insert(expected_q.size(), r);
        fill = 0;
        pred_mass = 1'b0;
        targ_mass = 1'b0;
        spilled = 1'b0;
    endfunction

    // accepted result: compare field by field with the oldest prediction
    function void check_result(logic [M_DATA_W-1:0] data);
        concordance_result_t got;
        concordance_result_t exp_r;
        got = data;
        n_checked++;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result transfer, data=%h", data);
            return;
        end
        exp_r = expected_q.pop_front();
        if (got.acc !== exp_r.acc || got.score !== exp_r.score ||
            got.pairs !== exp_r.pairs || got.status !== exp_r.status ||
            got.pad !== exp_r.pad) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on result %0d: expected acc=%0d score=%0d pairs=%0d status=%0d pad=%h, got acc=%0d score=%0d pairs=%0d status=%0d pad=%h",
                         n_checked, exp_r.acc, exp_r.score, exp_r.pairs, exp_r.status,
                         exp_r.pad, got.acc, got.score, got.pairs, got.status, got.pad);
        end
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction
endclass

module tb_pairwise_order_concordance;

    localparam int CLK_PERIOD   = 10;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int WALK_CYCLES  = 2200;
    // longer than a full-store run, so a second run piles up behind the held result
    localparam int HOLD_CYCLES  = 5000;
    localparam int PHASE_ITEMS  = 440;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;   // predicted_value [31:0], target_value [63:32]
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;   // accuracy_q16, score_halves, pairs_counted, status

    int                     send_gap_pct;
    int                     recv_stall_pct;
    bit                     hold_req;
    int unsigned            entries_sent;
    concordance_scoreboard  sb;

    pairwise_order_concordance uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // run limit
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAIL pairwise_order_concordance");
        $finish;
    end

    // monitor both channels at the clock edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_entry(s_tdata[IN_VALUE_W-1:0], s_tdata[S_DATA_W-1:IN_VALUE_W], s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // one entry transfer, with random gaps in front of it
    task automatic send_entry(input logic [IN_VALUE_W-1:0] pv,
                              input logic [IN_VALUE_W-1:0] tv, input logic lst);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tv, pv};
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        entries_sent++;
    endtask

    // weight drawn from one of several value shapes
    function automatic logic [IN_VALUE_W-1:0] pick_weight(input int shape);
        logic [IN_VALUE_W-1:0] w;
        case (shape)
            0: w = $urandom_range(3);
            1: w = $urandom;
            2: begin
                case ($urandom_range(3))
                    0: w = '0;
                    1: w = '1;
                    2: w = 32'h8000_0000;
                    default: w = 32'h0000_0001;
                endcase
            end
            default: w = $urandom_range(15) << $urandom_range(28);
        endcase
        return w;
    endfunction

    // one distribution; a shape of 4 mixes shapes per entry
    task automatic send_run(input int len, input int shape, input bit no_pred,
                            input bit no_targ);
        logic [IN_VALUE_W-1:0] pv;
        logic [IN_VALUE_W-1:0] tv;
        int s;
        for (int i = 0; i < len; i++) begin
            s  = (shape == 4) ? $urandom_range(3) : shape;
            pv = no_pred ? '0 : pick_weight(s);
            tv = no_targ ? '0 : pick_weight(s);
            send_entry(pv, tv, i == len - 1);
        end
    endtask

    // random part of one idling phase
    task automatic random_phase(input int phase);
        int unsigned stop_at;
        int pick;
        stop_at = entries_sent + PHASE_ITEMS;
        // one full store and one overflowing store per phase
        send_run(64, 4, 1'b0, 1'b0);
        send_run(65 + $urandom_range(3), 4, phase == 1, 1'b0);
        while (entries_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 75)
                send_run(1 + $urandom_range(9), $urandom_range(4), 1'b0, 1'b0);
            else if (pick < 88)
                send_run(11 + $urandom_range(13), $urandom_range(4), 1'b0, 1'b0);
            else if (pick < 94)
                send_run(1 + $urandom_range(5), $urandom_range(4), $urandom_range(1), 1'b0);
            else
                send_run(1 + $urandom_range(5), $urandom_range(4), 1'b0, 1'b1);
        end
    endtask

    // stimulus and end of run
    initial begin
        sb = new();
        entries_sent = 0;
        hold_req = 1'b0;
        send_gap_pct = 15;
        recv_stall_pct = 87;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single entry: no pairs, full accuracy
        send_entry(32'd5, 32'd7, 1'b1);
        // single zero entry: no mass at all
        send_entry(32'd0, 32'd0, 1'b1);
        // agreeing pair across the full value range
        send_entry(32'h0000_0001, 32'h0000_0001, 1'b0);
        send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // opposite order
        send_entry(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_entry(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        // predicted tie scores a half
        send_entry(32'd7, 32'd1, 1'b0);
        send_entry(32'd7, 32'd2, 1'b1);
        // all targets tied: no pair counts
        send_entry(32'd1, 32'd9, 1'b0);
        send_entry(32'd2, 32'd9, 1'b0);
        send_entry(32'd3, 32'd9, 1'b1);
        // predicted side without mass
        send_entry(32'd0, 32'd1, 1'b0);
        send_entry(32'd0, 32'd2, 1'b1);
        // target side without mass
        send_entry(32'd4, 32'd0, 1'b0);
        send_entry(32'd5, 32'd0, 1'b1);
        // mixed order with a rounded accuracy
        send_entry(32'd10, 32'd1, 1'b0);
        send_entry(32'd20, 32'd3, 1'b0);
        send_entry(32'd30, 32'd2, 1'b0);
        send_entry(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct = 15;
                    recv_stall_pct = 87;
                end
                1: begin
                    send_gap_pct = 87;
                    recv_stall_pct = 15;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                    hold_req = 1'b1;
                end
            endcase
            random_phase(phase);
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // drain, then watch for stray results for one full walk
        while (sb.pending() != 0) @(posedge aclk);
        repeat (WALK_CYCLES) @(posedge aclk);

        $display("covered %0d entries, %0d results: %0d scored (up to %0d pairs), %0d without mass, %0d overflowed",
                 sb.n_entries, sb.n_checked, sb.n_scored, sb.max_pairs, sb.n_no_mass,
                 sb.n_overflow);
        $display("idling covered sender-light, receiver-light and none, plus a %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS pairwise_order_concordance");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
            $display("FAIL pairwise_order_concordance");
        end
        $finish;
    end

endmodule
